/* rtl/distinct_neighbour_walk_top_macros.svh */
// Assertion macros shared by the distinct neighbour walk RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DISTINCT_NEIGHBOUR_WALK_TOP_MACROS_SVH
`define DISTINCT_NEIGHBOUR_WALK_TOP_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define DNW_ASSERT_ALWAYS(name, ck, rn, cond) \
    name: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define DNW_ASSERT_IMPLY(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define DNW_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/dnw_pkg.sv */
// Package of the distinct neighbour walk: field widths, codes, command and state types.
// Depends on nothing; imported by every module of the block.
package dnw_pkg;

    localparam int COUNT_W      = 7;
    localparam int DIR_W        = 2;
    localparam int RESULT_LIMIT = 64;
    localparam int LANE_W       = 6;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_SLOT_COUNT = '0;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_QUERY,
        CMD_EMPTY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               forward;
        logic [COUNT_W-1:0] want;
    } cmd_ctrl_t;

    typedef enum logic [2:0] {
        W_IDLE,
        W_HERE,
        W_COMP,
        W_DECIDE,
        W_FINISH
    } walk_state_t;

endpackage

/* rtl/dnw_front.sv */
// Front end of the distinct neighbour walk: accepts input words and classifies them.
// Depends on dnw_pkg; feeds the command queue.
module dnw_front #(
    parameter int SLOT_DEPTH = 64,
    parameter int ID_WIDTH   = 16,
    localparam int SLOT_W    = $clog2(SLOT_DEPTH),
    localparam int UW        = $clog2(SLOT_DEPTH + 1),
    localparam int IN_BITS   = SLOT_W + ID_WIDTH + dnw_pkg::COUNT_W + dnw_pkg::DIR_W,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                s_tvalid,
    output logic                s_tready,
    // slot_index, image_id, want_count, direction, zero padding
    input  logic [IN_W-1:0]     s_tdata,
    // mode
    input  logic                s_tuser,
    input  logic [UW-1:0]       used,
    input  logic                fifo_full,
    output logic                push,
    output dnw_pkg::cmd_ctrl_t  cmd_ctrl,
    output logic [SLOT_W-1:0]   cmd_slot,
    output logic [ID_WIDTH-1:0] cmd_id
);
    import dnw_pkg::*;

    logic [COUNT_W-1:0] want;
    logic [DIR_W-1:0]   dir;
    logic [UW-1:0]      slot_ext;
    logic               empty_answer;
    logic               write_in_range;

    assign cmd_slot = s_tdata[SLOT_W-1:0];
    assign cmd_id   = s_tdata[SLOT_W +: ID_WIDTH];
    assign want     = s_tdata[SLOT_W + ID_WIDTH +: COUNT_W];
    assign dir      = s_tdata[SLOT_W + ID_WIDTH + COUNT_W +: DIR_W];

    assign slot_ext       = UW'(cmd_slot);
    assign write_in_range = slot_ext < UW'(SLOT_DEPTH);
    assign empty_answer   = (want == '0) || (used == '0) || (slot_ext >= used)
                            || (dir == DIR_NONE);

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready && ((s_tuser == MODE_QUERY) || write_in_range);

    always_comb
    begin
        cmd_ctrl.forward = (dir == DIR_FWD);
        cmd_ctrl.want    = (want > COUNT_W'(RESULT_LIMIT)) ? COUNT_W'(RESULT_LIMIT) : want;
        if (s_tuser == MODE_WRITE)
        begin
            cmd_ctrl.kind = CMD_WRITE;
        end
        else if (empty_answer)
        begin
            cmd_ctrl.kind = CMD_EMPTY;
        end
        else
        begin
            cmd_ctrl.kind = CMD_QUERY;
        end
    end

endmodule

/* rtl/dnw_cmd_fifo.sv */
// Short command queue between the front end and the walker.
// Depends on dnw_pkg and the assertion macro header.
`include "distinct_neighbour_walk_top_macros.svh"

module dnw_cmd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic             nonempty,
    output logic [WIDTH-1:0] dout
);
    import dnw_pkg::*;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign dout     = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    `DNW_ASSERT_ALWAYS(a_fifo_bound, clk, rst_n, count_reg <= CW'(DEPTH))
    `DNW_ASSERT_IMPLY(a_fifo_ptrs, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg)

endmodule

/* rtl/dnw_walker.sv */
// Back end of the distinct neighbour walk: slot memory, walk sequencer and result register.
// Depends on dnw_pkg and the assertion macro header; fed by the command queue.
`include "distinct_neighbour_walk_top_macros.svh"

module dnw_walker #(
    parameter int SLOT_DEPTH = 64,
    parameter int ID_WIDTH   = 16,
    localparam int SLOT_W    = $clog2(SLOT_DEPTH),
    localparam int UW        = $clog2(SLOT_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [UW-1:0]       used,
    input  logic                cmd_valid,
    input  dnw_pkg::cmd_ctrl_t  cmd_ctrl,
    input  logic [SLOT_W-1:0]   cmd_slot,
    input  logic [ID_WIDTH-1:0] cmd_id,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ID_WIDTH-1:0] m_id,
    output logic                m_found,
    output logic                m_last
);
    import dnw_pkg::*;

    walk_state_t state_reg, state_next;

    logic [ID_WIDTH-1:0]     mem [SLOT_DEPTH];
    logic [ID_WIDTH-1:0]     rd_data_reg;
    logic                    mem_we, mem_re;
    logic [SLOT_W-1:0]       rd_addr;

    logic [SLOT_W-1:0]       pos_reg, pos_next;
    logic [COUNT_W-1:0]      want_reg, want_next;
    logic                    fwd_reg, fwd_next;
    logic [COUNT_W-1:0]      n_reg, n_next;
    logic [ID_WIDTH-1:0]     here_reg, here_next;
    logic [ID_WIDTH-1:0]     cand_reg, cand_next;
    logic                    skip_reg, skip_next;
    logic [RESULT_LIMIT-1:0] match_reg, match_next;
    logic [ID_WIDTH-1:0]     emit_id_reg [RESULT_LIMIT];
    logic [ID_WIDTH-1:0]     emit_id_next [RESULT_LIMIT];
    logic [RESULT_LIMIT-1:0] emit_valid_reg, emit_valid_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [ID_WIDTH-1:0]     pend_id_reg, pend_id_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ID_WIDTH-1:0]     out_id_reg, out_id_next;
    logic                    out_found_reg, out_found_next;
    logic                    out_last_reg, out_last_next;

    logic [UW-1:0]           pos_up;
    logic [SLOT_W-1:0]       pos_step;
    logic                    at_end;
    logic                    out_free;
    logic                    seen;
    logic                    reach_want;
    logic                    advance;

    assign pos_up     = UW'(pos_reg) + UW'(1);
    assign at_end     = fwd_reg ? (pos_up >= used) : (pos_reg == '0);
    assign pos_step   = fwd_reg ? pos_reg + SLOT_W'(1) : pos_reg - SLOT_W'(1);
    assign out_free   = !out_valid_reg || m_tready;
    assign seen       = (|match_reg) || skip_reg;
    assign reach_want = ((n_reg + COUNT_W'(1)) == want_reg);
    assign advance    = seen || !pend_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_id     = out_id_reg;
    assign m_found  = out_found_reg;
    assign m_last   = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (cmd_valid && (cmd_ctrl.kind == CMD_QUERY))
                begin
                    state_next = W_HERE;
                end
            end
            W_HERE:
            begin
                state_next = at_end ? W_FINISH : W_COMP;
            end
            W_COMP:
            begin
                state_next = W_DECIDE;
            end
            W_DECIDE:
            begin
                if (advance)
                begin
                    if ((!seen && reach_want) || at_end)
                    begin
                        state_next = W_FINISH;
                    end
                    else
                    begin
                        state_next = W_COMP;
                    end
                end
            end
            W_FINISH:
            begin
                if (out_free)
                begin
                    state_next = W_IDLE;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_addr         = pos_step;
        cmd_pop         = 1'b0;
        pos_next        = pos_reg;
        want_next       = want_reg;
        fwd_next        = fwd_reg;
        n_next          = n_reg;
        here_next       = here_reg;
        cand_next       = cand_reg;
        skip_next       = skip_reg;
        match_next      = match_reg;
        emit_id_next    = emit_id_reg;
        emit_valid_next = emit_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_found_next  = out_found_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            W_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_ctrl.kind)
                        CMD_WRITE:
                        begin
                            mem_we  = 1'b1;
                            cmd_pop = 1'b1;
                        end
                        CMD_QUERY:
                        begin
                            cmd_pop         = 1'b1;
                            mem_re          = 1'b1;
                            rd_addr         = cmd_slot;
                            pos_next        = cmd_slot;
                            want_next       = cmd_ctrl.want;
                            fwd_next        = cmd_ctrl.forward;
                            n_next          = '0;
                            emit_valid_next = '0;
                            pend_valid_next = 1'b0;
                        end
                        CMD_EMPTY:
                        begin
                            if (out_free)
                            begin
                                cmd_pop        = 1'b1;
                                out_valid_next = 1'b1;
                                out_id_next    = '0;
                                out_found_next = 1'b0;
                                out_last_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            W_HERE:
            begin
                here_next = rd_data_reg;
                if (!at_end)
                begin
                    mem_re   = 1'b1;
                    pos_next = pos_step;
                end
            end
            W_COMP:
            begin
                cand_next = rd_data_reg;
                skip_next = (rd_data_reg == here_reg);
                for (int i = 0; i < RESULT_LIMIT; i++)
                begin
                    match_next[i] = emit_valid_reg[i] && (emit_id_reg[i] == rd_data_reg);
                end
            end
            W_DECIDE:
            begin
                if (advance)
                begin
                    if (!seen)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_id_next    = pend_id_reg;
                            out_found_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next                     = 1'b1;
                        pend_id_next                        = cand_reg;
                        emit_id_next[n_reg[LANE_W-1:0]]     = cand_reg;
                        emit_valid_next[n_reg[LANE_W-1:0]]  = 1'b1;
                        n_next                              = n_reg + COUNT_W'(1);
                    end
                    if (!((!seen && reach_want) || at_end))
                    begin
                        mem_re   = 1'b1;
                        pos_next = pos_step;
                    end
                end
            end
            W_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = pend_valid_reg ? pend_id_reg : '0;
                    out_found_next  = pend_valid_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= W_IDLE;
            n_reg          <= '0;
            emit_valid_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            n_reg          <= n_next;
            emit_valid_reg <= emit_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        want_reg      <= want_next;
        fwd_reg       <= fwd_next;
        here_reg      <= here_next;
        cand_reg      <= cand_next;
        skip_reg      <= skip_next;
        match_reg     <= match_next;
        emit_id_reg   <= emit_id_next;
        pend_id_reg   <= pend_id_next;
        out_id_reg    <= out_id_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cmd_slot] <= cmd_id;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    `DNW_ASSERT_ALWAYS(a_lanes_match_count, clk, rst_n, $countones(emit_valid_reg) == n_reg)
    `DNW_ASSERT_IMPLY(a_pending_has_count, clk, rst_n, pend_valid_reg, n_reg != '0)
    `DNW_ASSERT_IMPLY(a_count_bound, clk, rst_n, state_reg != W_IDLE, n_reg <= want_reg)
    `DNW_ASSERT_NEXT(a_decide_follows_comp, clk, rst_n, state_reg == W_COMP, state_reg == W_DECIDE)

endmodule

/* rtl/distinct_neighbour_walk_top.sv */
// Top level of the distinct neighbour walk: configuration port, front end, queue and walker.
// Depends on dnw_pkg, dnw_front, dnw_cmd_fifo and dnw_walker.
//
// Write words store one identifier into the slot memory. A query that yields an empty answer
// gives one result with found low and no walk; any other query walks the slots one at a time,
// since each slot needs one registered read of the single-port slot memory followed by a
// compare against the start slot's identifier and all identifiers already chosen, and a
// decision. The walker handles one query at a time, while a
// two-entry queue lets the input side accept further words meanwhile and a result register
// lets the output side stall on its own. The slot memory is not cleared; a slot must be written
// before a query reads it.
module distinct_neighbour_walk_top #(
    parameter int SLOT_DEPTH = 64,
    parameter int ID_WIDTH   = 16,
    localparam int SLOT_W    = $clog2(SLOT_DEPTH),
    localparam int IN_BITS   = SLOT_W + ID_WIDTH + dnw_pkg::COUNT_W + dnw_pkg::DIR_W,
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((ID_WIDTH + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // slot_index, image_id, want_count, direction, zero padding
    input  logic [IN_W-1:0]              s_tdata,
    // mode
    input  logic                         s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // neighbour_id, zero padding
    output logic [OUT_W-1:0]             m_tdata,
    // found
    output logic                         m_tuser,
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dnw_pkg::PADDR_W-1:0]  paddr,
    input  logic [dnw_pkg::PDATA_W-1:0]  pwdata,
    output logic [dnw_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import dnw_pkg::*;

    localparam int UW    = $clog2(SLOT_DEPTH + 1);
    localparam int EW    = (UW > COUNT_W) ? UW : COUNT_W;
    localparam int CMD_W = $bits(cmd_ctrl_t) + SLOT_W + ID_WIDTH;

    logic [COUNT_W-1:0]  slot_count_reg, slot_count_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [EW-1:0]       count_ext;
    logic [UW-1:0]       used;

    logic                push, fifo_full, fifo_nonempty, cmd_pop;
    cmd_ctrl_t           front_ctrl, walk_ctrl;
    logic [SLOT_W-1:0]   front_slot, walk_slot;
    logic [ID_WIDTH-1:0] front_id, walk_id;
    logic [CMD_W-1:0]    fifo_din, fifo_dout;
    logic [ID_WIDTH-1:0] result_id;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_SLOT_COUNT) ? PDATA_W'(slot_count_reg) : '0;

    always_comb
    begin
        slot_count_next = slot_count_reg;
        if (psel && penable && pwrite && pready && (reg_idx == REG_SLOT_COUNT))
        begin
            slot_count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= '0;
        end
        else
        begin
            slot_count_reg <= slot_count_next;
        end
    end

    assign count_ext = EW'(slot_count_reg);
    assign used      = (count_ext > EW'(SLOT_DEPTH)) ? UW'(SLOT_DEPTH) : UW'(count_ext);

    dnw_front #(
        .SLOT_DEPTH (SLOT_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .used      (used),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd_ctrl  (front_ctrl),
        .cmd_slot  (front_slot),
        .cmd_id    (front_id)
    );

    assign fifo_din = {front_ctrl, front_slot, front_id};

    dnw_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (2)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .din      (fifo_din),
        .full     (fifo_full),
        .pop      (cmd_pop),
        .nonempty (fifo_nonempty),
        .dout     (fifo_dout)
    );

    assign {walk_ctrl, walk_slot, walk_id} = fifo_dout;

    dnw_walker #(
        .SLOT_DEPTH (SLOT_DEPTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .used      (used),
        .cmd_valid (fifo_nonempty),
        .cmd_ctrl  (walk_ctrl),
        .cmd_slot  (walk_slot),
        .cmd_id    (walk_id),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_id      (result_id),
        .m_found   (m_tuser),
        .m_last    (m_tlast)
    );

    assign m_tdata = OUT_W'(result_id);

endmodule
